[sv/efm_pkg.sv]
package efm_pkg;

	localparam int CHANNELS   = 8;
	localparam int TIME_BITS  = 32;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CHAN_W     = 3;
	localparam int TS_W       = 32;
	localparam int AVG_W      = 20;
	localparam int FREQ_W     = 20;
	localparam int W_W        = 10;
	localparam int ACC_W      = 30;
	localparam int TOUT_W     = 20;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [W_W-1:0]    PER_MILLE     = W_W'(1000);
	localparam logic [ACC_W-1:0]  ONE_MILLION   = ACC_W'(1000000);
	localparam logic [TOUT_W-1:0] TIMEOUT_RESET = TOUT_W'(1337);
	localparam logic [W_W-1:0]    WEIGHT_RESET  = W_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT,
		REG_WEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_MAC,
		S_DIVA,
		S_RECIP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	typedef struct packed {
		logic [TS_W-1:0]  last_time;
		logic [AVG_W-1:0] avg;
	} entry_t;

endpackage

[sv/efm_in_if.sv]
interface efm_in_if;
	import efm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel;
	logic [TS_W-1:0]   timestamp_us;

	modport source(output valid, channel, timestamp_us, input ready);
	modport sink(input valid, channel, timestamp_us, output ready);
endinterface

[sv/efm_out_if.sv]
interface efm_out_if;
	import efm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel_out;
	logic [FREQ_W-1:0] freq_hz;
	logic              timed_out;
	logic [AVG_W-1:0]  avg_period_us;

	modport source(output valid, channel_out, freq_hz, timed_out, avg_period_us, input ready);
	modport sink(input valid, channel_out, freq_hz, timed_out, avg_period_us, output ready);
endinterface

[sv/efm_cfg_if.sv]
interface efm_cfg_if;
	import efm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[sv/efm_mac.sv]
module efm_mac
	import efm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W_W-1:0]     weight_a,
	input  logic [AVG_W-1:0]   a,
	input  logic [W_W-1:0]     weight_b,
	input  logic [AVG_W-1:0]   b,
	output logic [ACC_W-1:0]   acc,
	output unit_status_t       status
);

	localparam int CNT_W = (W_W > 1) ? $clog2(W_W) : 1;

	logic [W_W-1:0]   wa_q, wb_q;
	logic [AVG_W-1:0] a_q, b_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	// msb-first shift and add, one weight bit of each product per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			wa_q  <= weight_a;
			wb_q  <= weight_b;
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << 1)
				+ (wa_q[W_W-1] ? ACC_W'(a_q) : '0)
				+ (wb_q[W_W-1] ? ACC_W'(b_q) : '0);
			wa_q  <= wa_q << 1;
			wb_q  <= wb_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign acc         = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

[sv/efm_div.sv]
module efm_div
	import efm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ACC_W-1:0]   dividend,
	input  logic [AVG_W-1:0]   divisor,
	output logic [ACC_W-1:0]   quotient,
	output unit_status_t       status
);

	localparam int CNT_W = $clog2(ACC_W);

	logic [AVG_W-1:0] rem_q, dvs_q;
	logic [ACC_W-1:0] dq_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	logic [AVG_W:0]   shifted, diff;
	logic             ge;

	// restoring step: dividend bits leave the top of dq, quotient bits enter below
	assign shifted = {rem_q, dq_q[ACC_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[AVG_W-1:0] : shifted[AVG_W-1:0];
			dq_q  <= {dq_q[ACC_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient    = dq_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

[sv/edge_frequency_meter_ema.sv]
// steps: a timed-out edge word goes from the channel check straight to the result; any other
// word runs 10 steps of the bit-serial multiply-add, then a 30-step pass of the shared serial
// divider by 1000 and, unless the new average comes out zero, a second 30-step pass of it
// (one million over the average); one edge word is handled at a time, and its result may
// wait for the output register to empty; the next word is taken once the sequencer is back
// at idle, while the previous result may still wait in the output register
// reset: clears control, sets timeout to 1337 us and weight to 8, all channels read as zero
module edge_frequency_meter_ema
	import efm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	efm_in_if.sink    edges,
	efm_out_if.source results,
	efm_cfg_if.sink   cfg
);

	state_t state_q, state_d;

	logic [TOUT_W-1:0] timeout_q;
	logic [W_W-1:0]    weight_q;

	entry_t            mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;

	logic [CHAN_W-1:0] ch_q;
	logic [TS_W-1:0]   ts_q;
	entry_t            rd_q;
	logic              rd_vld_q;
	logic              tout_q;
	logic [AVG_W-1:0]  avg_new_q;
	logic [FREQ_W-1:0] freq_q;

	logic              out_valid_q;
	logic [CHAN_W-1:0] out_ch_q;
	logic [FREQ_W-1:0] out_freq_q;
	logic              out_tout_q;
	logic [AVG_W-1:0]  out_avg_q;

	logic              ch_ok;
	logic [CH_W-1:0]   ch_idx;
	logic [TS_W-1:0]   last_time;
	logic [AVG_W-1:0]  old_avg;
	logic [63:0]       diff;
	logic [TIME_BITS-1:0] interval;
	logic              too_long;
	logic [W_W-1:0]    w_sat, w_comp;

	logic              mac_start, div_start, fire;
	logic [ACC_W-1:0]  mac_acc, div_quo, div_dvd;
	logic [AVG_W-1:0]  div_dvs;
	logic              quo_zero;
	unit_status_t      mac_st, div_st;

	assign ch_ok  = 32'(edges.channel) < CHANNELS;
	assign ch_idx = CH_W'(ch_q);

	assign last_time = rd_vld_q ? rd_q.last_time : '0;
	assign old_avg   = rd_vld_q ? rd_q.avg : '0;
	assign diff      = 64'(ts_q) - 64'(last_time);
	assign interval  = diff[TIME_BITS-1:0];
	assign too_long  = 64'(interval) > 64'(timeout_q);

	assign w_sat    = (weight_q > PER_MILLE) ? PER_MILLE : weight_q;
	assign w_comp   = PER_MILLE - w_sat;
	assign quo_zero = div_quo[AVG_W-1:0] == '0;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			weight_q  <= WEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TIMEOUT: timeout_q <= cfg.data[TOUT_W-1:0];
				REG_WEIGHT:  weight_q  <= cfg.data[W_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (edges.valid && ch_ok) state_d = S_READ;
			S_READ:  state_d = S_CHECK;
			S_CHECK: state_d = too_long ? S_DONE : S_MAC;
			S_MAC:   if (mac_st.done) state_d = S_DIVA;
			S_DIVA:  if (div_st.done) state_d = quo_zero ? S_DONE : S_RECIP;
			S_RECIP: if (div_st.done) state_d = S_DONE;
			S_DONE:  if (!out_valid_q || results.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		edges.ready = state_q == S_IDLE;
		mac_start   = (state_q == S_CHECK) && !too_long;
		div_start   = ((state_q == S_MAC) && mac_st.done)
			|| ((state_q == S_DIVA) && div_st.done && !quo_zero);
		fire        = (state_q == S_DONE) && (!out_valid_q || results.ready);
		// first pass divides the weighted sum by 1000, second takes the reciprocal
		if (state_q == S_MAC) begin
			div_dvd = mac_acc;
			div_dvs = AVG_W'(PER_MILLE);
		end else begin
			div_dvd = ONE_MILLION;
			div_dvs = div_quo[AVG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// channel store
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_q <= mem[ch_idx];
		end
		if (fire) begin
			mem[ch_idx] <= {ts_q, avg_new_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire) begin
			valid_q[ch_idx] <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (edges.valid && edges.ready) begin
			ch_q <= edges.channel;
			ts_q <= edges.timestamp_us;
		end
		if (state_q == S_READ) begin
			rd_vld_q <= valid_q[ch_idx];
		end
		if (state_q == S_CHECK) begin
			tout_q    <= too_long;
			avg_new_q <= old_avg;
			freq_q    <= '0;
		end
		if ((state_q == S_DIVA) && div_st.done) begin
			avg_new_q <= div_quo[AVG_W-1:0];
		end
		if ((state_q == S_RECIP) && div_st.done) begin
			freq_q <= div_quo[FREQ_W-1:0];
		end
	end

	efm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mac_start),
		.weight_a (w_sat),
		.a        (AVG_W'(interval)),
		.weight_b (w_comp),
		.b        (old_avg),
		.acc      (mac_acc),
		.status   (mac_st)
	);

	efm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.status   (div_st)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_ch_q   <= ch_q;
			out_freq_q <= freq_q;
			out_tout_q <= tout_q;
			out_avg_q  <= avg_new_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.channel_out   = out_ch_q;
	assign results.freq_hz       = out_freq_q;
	assign results.timed_out     = out_tout_q;
	assign results.avg_period_us = out_avg_q;

	a_tout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.timed_out |-> results.freq_hz == '0)
		else $error("timed-out result with nonzero frequency");

	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.avg_period_us == '0) |-> results.freq_hz == '0)
		else $error("zero average with nonzero frequency");

	a_mac_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_st.busy |-> state_q == S_MAC)
		else $error("multiplier running outside its state");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == S_DIVA) || (state_q == S_RECIP))
		else $error("divider running outside its states");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		edges.valid && edges.ready && ch_ok |=> state_q == S_READ)
		else $error("accepted edge word not read from the channel store");

endmodule
